@@ sv/fcgi_nv_pkg.sv @@
// Shared types, codes and constants for the FastCGI name-value encoder.
package fcgi_nv_pkg;

  localparam int NAME_DEPTH_DEF  = 128;
  localparam int VALUE_DEPTH_DEF = 4096;

  localparam logic [31:0] SHORT_MAX = 32'd127;
  localparam logic [7:0]  LONG_MARK = 8'h80;
  localparam logic [7:0]  EQ_BYTE   = 8'h3D;
  localparam logic [7:0]  NUL_BYTE  = 8'h00;
  localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;

  // request kinds, decided by the front end
  localparam logic [1:0] CMD_PULL = 2'd0;
  localparam logic [1:0] CMD_ZERO = 2'd1;
  localparam logic [1:0] CMD_EQ   = 2'd2;
  localparam logic [1:0] CMD_DATA = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } cmd_t;

  // One byte of a length prefix: short form for 127 or less, else four
  // big-endian bytes with the top bit of the first one set.
  function automatic logic [7:0] pfx_byte(input logic [31:0] len, input logic [1:0] k);
    logic [7:0] b;
    if (len <= SHORT_MAX) begin
      b = len[7:0];
    end else begin
      case (k)
        2'd0:    b = LONG_MARK | {1'b0, len[30:24]};
        2'd1:    b = len[23:16];
        2'd2:    b = len[15:8];
        default: b = len[7:0];
      endcase
    end
    return b;
  endfunction

endpackage

@@ sv/fcgi_nv_in_if.sv @@
// Input request channel: push or pull mode plus the pushed byte.
interface fcgi_nv_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] in_byte;

  modport source (output valid, output mode, output in_byte, input ready);
  modport sink   (input valid, input mode, input in_byte, output ready);
endinterface

@@ sv/fcgi_nv_out_if.sv @@
// Result channel: one result per request.
interface fcgi_nv_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_valid;
  logic        pair_last;
  logic        block_done;
  logic [1:0]  status;
  logic [23:0] encoded_count;

  modport source (output valid, output out_byte, output out_valid, output pair_last,
                  output block_done, output status, output encoded_count, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input pair_last,
                  input block_done, input status, input encoded_count, output ready);
endinterface

@@ sv/fastcgi_name_value_encoder.sv @@
// Top level of the FastCGI name-value pair encoder.
//
//   channel | dir | payload                                   | handshake
//   --------+-----+-------------------------------------------+------------
//   in_if   | in  | mode, in_byte                             | valid/ready
//   out_if  | out | out_byte, out_valid, pair_last,           | valid/ready
//           |     | block_done, status, encoded_count         |
//
// Every request (push or pull) yields exactly one result. Sustained rate is
// one request per cycle while results are taken, set by the back end, which
// retires one command a cycle with a single access to the name or value
// store. A request is written into the command queue; when the back end
// takes it, its result and any store read land in the result register.
// Reset (rst_n low at a clock edge) empties the queue and the result
// register and returns to waiting for a leading separator; the stores are
// not cleared. A stalled result holds the back end; the two-entry queue
// keeps the front end taking requests until it fills.
module fastcgi_name_value_encoder #(
  parameter int NAME_DEPTH  = fcgi_nv_pkg::NAME_DEPTH_DEF,
  parameter int VALUE_DEPTH = fcgi_nv_pkg::VALUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  fcgi_nv_in_if.sink    in_if,
  fcgi_nv_out_if.source out_if
);

  // front end to queue
  logic              q_push;
  logic              q_full;
  fcgi_nv_pkg::cmd_t q_push_cmd;

  // queue to back end
  logic              q_pop;
  logic              q_avail;
  fcgi_nv_pkg::cmd_t q_head_cmd;

  // classify each request: pull, zero byte, '=' or plain data
  fcgi_nv_front u_front (
    .in_if  (in_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_push_cmd)
  );

  // decouple front and back so each side can stall on its own
  fcgi_nv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head_cmd (q_head_cmd)
  );

  // buffer the pair, then drain prefixes, name and value on pulls
  fcgi_nv_back #(
    .NAME_DEPTH  (NAME_DEPTH),
    .VALUE_DEPTH (VALUE_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_avail (q_avail),
    .q_cmd   (q_head_cmd),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

@@ sv/fcgi_nv_front.sv @@
// Front end: accept requests and classify each one into a command.
module fcgi_nv_front (
  fcgi_nv_in_if.sink        in_if,
  input  logic              q_full,
  output logic              q_push,
  output fcgi_nv_pkg::cmd_t q_cmd
);

  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  always_comb begin
    q_cmd.data = in_if.in_byte;
    if (in_if.mode) begin
      q_cmd.kind = fcgi_nv_pkg::CMD_PULL;
    end else if (in_if.in_byte == fcgi_nv_pkg::NUL_BYTE) begin
      q_cmd.kind = fcgi_nv_pkg::CMD_ZERO;
    end else if (in_if.in_byte == fcgi_nv_pkg::EQ_BYTE) begin
      q_cmd.kind = fcgi_nv_pkg::CMD_EQ;
    end else begin
      q_cmd.kind = fcgi_nv_pkg::CMD_DATA;
    end
  end

endmodule

@@ sv/fcgi_nv_queue.sv @@
// Two-entry command queue between front end and back end.
module fcgi_nv_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fcgi_nv_pkg::cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              avail,
  output fcgi_nv_pkg::cmd_t head_cmd
);

  fcgi_nv_pkg::cmd_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign avail    = (cnt_r != 2'd0);
  assign head_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ sv/fcgi_nv_back.sv @@
// Back end: pair buffering, drain sequencer, stores and result register.
module fcgi_nv_back #(
  parameter int NAME_DEPTH  = fcgi_nv_pkg::NAME_DEPTH_DEF,
  parameter int VALUE_DEPTH = fcgi_nv_pkg::VALUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_avail,
  input  fcgi_nv_pkg::cmd_t q_cmd,
  output logic              q_pop,
  fcgi_nv_out_if.source     out_if
);

  localparam int NLEN_W = $clog2(NAME_DEPTH + 1);
  localparam int VLEN_W = $clog2(VALUE_DEPTH + 1);
  localparam int NAW    = $clog2(NAME_DEPTH);
  localparam int VAW    = $clog2(VALUE_DEPTH);
  localparam int DPW0   = (NLEN_W > VLEN_W) ? NLEN_W : VLEN_W;
  localparam int DPOS_W = (DPW0 > 4) ? DPW0 : 4;

  localparam logic [2:0] PH_LEAD       = 3'd0;
  localparam logic [2:0] PH_NAME_START = 3'd1;
  localparam logic [2:0] PH_NAME       = 3'd2;
  localparam logic [2:0] PH_VALUE      = 3'd3;
  localparam logic [2:0] PH_HEAD       = 3'd4;
  localparam logic [2:0] PH_DNAME      = 3'd5;
  localparam logic [2:0] PH_DVALUE     = 3'd6;

  localparam logic [1:0] SRC_HDR   = 2'd0;
  localparam logic [1:0] SRC_NAME  = 2'd1;
  localparam logic [1:0] SRC_VALUE = 2'd2;

  logic [7:0] name_mem  [NAME_DEPTH];
  logic [7:0] value_mem [VALUE_DEPTH];
  logic [7:0] name_rd_r, value_rd_r;

  logic [2:0]        phase_r, phase_nxt;
  logic [NLEN_W-1:0] nlen_r, nlen_nxt;
  logic [VLEN_W-1:0] vlen_r, vlen_nxt;
  logic [DPOS_W-1:0] dpos_r, dpos_nxt;
  logic [23:0]       total_r, total_nxt;

  logic        res_v_r;
  logic [1:0]  res_src_r, res_src_nxt;
  logic [7:0]  res_hdr_r, res_hdr_nxt;
  logic        res_ov_r, res_ov_nxt;
  logic        res_last_r, res_last_nxt;
  logic        res_done_r, res_done_nxt;
  logic [1:0]  res_st_r, res_st_nxt;
  logic [23:0] res_cnt_r, res_cnt_nxt;

  logic              fire;
  logic              draining;
  logic              name_we, value_we, name_re, value_re;
  logic [DPOS_W-1:0] dpos_inc;
  logic [2:0]        nh, nv;
  logic [3:0]        hdr_end;
  logic              in_name_pfx;
  logic [DPOS_W-1:0] vpos;
  logic [1:0]        pfx_k;
  logic [31:0]       pfx_len;

  assign fire  = q_avail && (!res_v_r || out_if.ready);
  assign q_pop = fire;

  assign draining = (phase_r == PH_HEAD) || (phase_r == PH_DNAME) || (phase_r == PH_DVALUE);
  assign dpos_inc = dpos_r + DPOS_W'(1);

  // header layout: name prefix then value prefix
  assign nh          = (32'(nlen_r) > fcgi_nv_pkg::SHORT_MAX) ? 3'd4 : 3'd1;
  assign nv          = (32'(vlen_r) > fcgi_nv_pkg::SHORT_MAX) ? 3'd4 : 3'd1;
  assign hdr_end     = {1'b0, nh} + {1'b0, nv};
  assign in_name_pfx = dpos_r < DPOS_W'(nh);
  assign vpos        = dpos_r - DPOS_W'(nh);
  assign pfx_k       = in_name_pfx ? dpos_r[1:0] : vpos[1:0];
  assign pfx_len     = in_name_pfx ? 32'(nlen_r) : 32'(vlen_r);

  always_comb begin
    phase_nxt    = phase_r;
    nlen_nxt     = nlen_r;
    vlen_nxt     = vlen_r;
    dpos_nxt     = dpos_r;
    total_nxt    = total_r;
    name_we      = 1'b0;
    value_we     = 1'b0;
    name_re      = 1'b0;
    value_re     = 1'b0;
    res_src_nxt  = SRC_HDR;
    res_hdr_nxt  = 8'h00;
    res_ov_nxt   = 1'b0;
    res_last_nxt = 1'b0;
    res_done_nxt = 1'b0;
    res_st_nxt   = fcgi_nv_pkg::ST_OK;
    res_cnt_nxt  = 24'd0;

    if (q_cmd.kind != fcgi_nv_pkg::CMD_PULL) begin
      if (draining) begin
        res_st_nxt = fcgi_nv_pkg::ST_REFUSED;
      end else begin
        unique case (phase_r)
          PH_NAME_START, PH_NAME: begin
            if (q_cmd.kind == fcgi_nv_pkg::CMD_EQ) begin
              phase_nxt = PH_VALUE;
            end else if (q_cmd.kind == fcgi_nv_pkg::CMD_ZERO) begin
              if (phase_r == PH_NAME_START) begin
                // zero where a name would start closes the block
                res_done_nxt = 1'b1;
                res_cnt_nxt  = total_r;
                phase_nxt    = PH_LEAD;
              end else begin
                dpos_nxt  = '0;
                phase_nxt = PH_HEAD;
              end
            end else begin
              phase_nxt = PH_NAME;
              if (nlen_r < NLEN_W'(NAME_DEPTH)) begin
                name_we  = 1'b1;
                nlen_nxt = nlen_r + NLEN_W'(1);
              end else begin
                res_st_nxt = fcgi_nv_pkg::ST_DROPPED;
              end
            end
          end
          PH_VALUE: begin
            if (q_cmd.kind == fcgi_nv_pkg::CMD_ZERO) begin
              dpos_nxt  = '0;
              phase_nxt = PH_HEAD;
            end else if (vlen_r < VLEN_W'(VALUE_DEPTH)) begin
              value_we = 1'b1;
              vlen_nxt = vlen_r + VLEN_W'(1);
            end else begin
              res_st_nxt = fcgi_nv_pkg::ST_DROPPED;
            end
          end
          default: begin
            // leading separator: skip it and start a new block
            total_nxt = 24'd0;
            nlen_nxt  = '0;
            vlen_nxt  = '0;
            dpos_nxt  = '0;
            phase_nxt = PH_NAME_START;
          end
        endcase
      end
    end else if (!draining) begin
      res_st_nxt = fcgi_nv_pkg::ST_EMPTY;
    end else begin
      res_ov_nxt = 1'b1;
      if (total_r < fcgi_nv_pkg::TOTAL_MAX) begin
        total_nxt = total_r + 24'd1;
      end
      dpos_nxt = dpos_inc;
      unique case (phase_r)
        PH_HEAD: begin
          res_hdr_nxt = fcgi_nv_pkg::pfx_byte(pfx_len, pfx_k);
          if (dpos_inc >= DPOS_W'(hdr_end)) begin
            dpos_nxt = '0;
            if (nlen_r != '0) begin
              phase_nxt = PH_DNAME;
            end else if (vlen_r != '0) begin
              phase_nxt = PH_DVALUE;
            end else begin
              res_last_nxt = 1'b1;
            end
          end
        end
        PH_DNAME: begin
          res_src_nxt = SRC_NAME;
          name_re     = 1'b1;
          if (dpos_inc >= DPOS_W'(nlen_r)) begin
            dpos_nxt = '0;
            if (vlen_r != '0) begin
              phase_nxt = PH_DVALUE;
            end else begin
              res_last_nxt = 1'b1;
            end
          end
        end
        default: begin
          res_src_nxt = SRC_VALUE;
          value_re    = 1'b1;
          if (dpos_inc >= DPOS_W'(vlen_r)) begin
            res_last_nxt = 1'b1;
          end
        end
      endcase
      if (res_last_nxt) begin
        nlen_nxt  = '0;
        vlen_nxt  = '0;
        dpos_nxt  = '0;
        phase_nxt = PH_NAME_START;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      nlen_r  <= '0;
      vlen_r  <= '0;
      dpos_r  <= '0;
      total_r <= 24'd0;
      res_v_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
        nlen_r  <= nlen_nxt;
        vlen_r  <= vlen_nxt;
        dpos_r  <= dpos_nxt;
        total_r <= total_nxt;
        res_v_r <= 1'b1;
      end else if (out_if.ready) begin
        res_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_src_r  <= res_src_nxt;
      res_hdr_r  <= res_hdr_nxt;
      res_ov_r   <= res_ov_nxt;
      res_last_r <= res_last_nxt;
      res_done_r <= res_done_nxt;
      res_st_r   <= res_st_nxt;
      res_cnt_r  <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && name_we) begin
      name_mem[nlen_r[NAW-1:0]] <= q_cmd.data;
    end
    if (fire && name_re) begin
      name_rd_r <= name_mem[dpos_r[NAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (fire && value_we) begin
      value_mem[vlen_r[VAW-1:0]] <= q_cmd.data;
    end
    if (fire && value_re) begin
      value_rd_r <= value_mem[dpos_r[VAW-1:0]];
    end
  end

  always_comb begin
    case (res_src_r)
      SRC_NAME:  out_if.out_byte = name_rd_r;
      SRC_VALUE: out_if.out_byte = value_rd_r;
      default:   out_if.out_byte = res_hdr_r;
    endcase
  end

  assign out_if.valid         = res_v_r;
  assign out_if.out_valid     = res_ov_r;
  assign out_if.pair_last     = res_last_r;
  assign out_if.block_done    = res_done_r;
  assign out_if.status        = res_st_r;
  assign out_if.encoded_count = res_cnt_r;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the FastCGI name-value encoder: a request table, then random blocks.
module tb;

  localparam int   NAME_DEPTH       = fcgi_nv_pkg::NAME_DEPTH_DEF;
  localparam int   VALUE_DEPTH      = fcgi_nv_pkg::VALUE_DEPTH_DEF;
  localparam logic MODE_PUSH        = 1'b0;
  localparam logic MODE_PULL        = 1'b1;
  localparam int   MAX_REPORTS      = 10;
  localparam int   RANDOM_PER_PHASE = 24;
  localparam int   TAIL_CYCLES      = 8;
  localparam int   DIR_ROWS         = 26;

  // Where the encoder stands between requests.
  typedef enum logic [2:0] {
    ENC_WAIT_LEAD,
    ENC_NAME_START,
    ENC_NAME,
    ENC_VALUE,
    ENC_HEADER,
    ENC_SEND_NAME,
    ENC_SEND_VALUE
  } enc_phase_t;

  // One result, laid out like the result channel payload.
  typedef struct packed {
    logic [7:0]  obyte;
    logic        ovalid;
    logic        plast;
    logic        bdone;
    logic [1:0]  status;
    logic [23:0] count;
  } enc_result_t;

  // One row of the request table. When pinned is set, exp is the result that
  // must come back; otherwise the predictor supplies it.
  typedef struct packed {
    logic        mode;
    logic [7:0]  data;
    logic        pinned;
    enc_result_t exp;
  } stim_row_t;

  // Request table: empty pull after reset, empty pair, refused push, a name
  // ended by a zero, a value holding '=' and 0x80, block end, empty pull.
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{MODE_PULL, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, fcgi_nv_pkg::ST_EMPTY,   24'd0}},
    '{MODE_PUSH, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, fcgi_nv_pkg::ST_OK,      24'd0}},
    '{MODE_PUSH, 8'h3D, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, fcgi_nv_pkg::ST_OK,      24'd0}},
    '{MODE_PUSH, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, fcgi_nv_pkg::ST_OK,      24'd0}},
    '{MODE_PUSH, 8'h41, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, fcgi_nv_pkg::ST_REFUSED, 24'd0}},
    '{MODE_PULL, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, fcgi_nv_pkg::ST_OK,      24'd0}},
    '{MODE_PULL, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, fcgi_nv_pkg::ST_OK,      24'd0}},
    '{MODE_PUSH, 8'h01, 1'b0, '0},
    '{MODE_PUSH, 8'hFE, 1'b0, '0},
    '{MODE_PUSH, 8'h00, 1'b0, '0},
    '{MODE_PULL, 8'hFF, 1'b0, '0},
    '{MODE_PULL, 8'h00, 1'b0, '0},
    '{MODE_PULL, 8'hAA, 1'b0, '0},
    '{MODE_PULL, 8'h55, 1'b0, '0},
    '{MODE_PUSH, 8'h6B, 1'b0, '0},
    '{MODE_PUSH, 8'h3D, 1'b0, '0},
    '{MODE_PUSH, 8'h3D, 1'b0, '0},
    '{MODE_PUSH, 8'h80, 1'b0, '0},
    '{MODE_PUSH, 8'h00, 1'b0, '0},
    '{MODE_PULL, 8'h00, 1'b0, '0},
    '{MODE_PULL, 8'h00, 1'b0, '0},
    '{MODE_PULL, 8'h00, 1'b0, '0},
    '{MODE_PULL, 8'h00, 1'b0, '0},
    '{MODE_PULL, 8'h00, 1'b0, '0},
    // 2 + 4 + 5 bytes were pulled in this block
    '{MODE_PUSH, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, fcgi_nv_pkg::ST_OK,      24'd11}},
    '{MODE_PULL, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, fcgi_nv_pkg::ST_EMPTY,   24'd0}}
  };

  logic clk;
  logic rst_n;

  fcgi_nv_in_if  in_ch ();
  fcgi_nv_out_if out_ch ();

  fastcgi_name_value_encoder #(
    .NAME_DEPTH (NAME_DEPTH),
    .VALUE_DEPTH(VALUE_DEPTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  // Predictor state: a private copy of the encoder's stores and counters.
  logic [7:0]  pr_name  [NAME_DEPTH];
  logic [7:0]  pr_value [VALUE_DEPTH];
  int unsigned pr_name_len  = 0;
  int unsigned pr_value_len = 0;
  int unsigned pr_pos       = 0;
  logic [23:0] pr_total     = '0;
  logic        pr_overflow  = 1'b0;
  enc_phase_t  pr_phase     = ENC_WAIT_LEAD;

  enc_result_t expected_results [$];

  int src_idle_pct    = 0;
  int sink_stall_pct  = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int pairs_done      = 0;
  int blocks_done     = 0;
  int drops           = 0;

  enc_result_t got;
  enc_result_t want;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bound the run well past the slowest legal schedule.
  initial begin
    #20_000_000;
    $display("timeout with %0d results still outstanding", expected_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Size of one length prefix.
  function automatic int unsigned prefix_len(input int unsigned len);
    return (len > fcgi_nv_pkg::SHORT_MAX) ? 4 : 1;
  endfunction

  // Byte k of the prefix for len; long form is big-endian with the mark bit.
  function automatic logic [7:0] prefix_byte_at(input int unsigned len, input int unsigned k);
    logic [31:0] l;
    logic [7:0]  b;
    l = len;
    if (l <= fcgi_nv_pkg::SHORT_MAX) begin
      return l[7:0];
    end
    b = 8'(l >> (8 * (3 - (k & 3))));
    if ((k & 3) == 0) begin
      b = fcgi_nv_pkg::LONG_MARK | (b & 8'h7F);
    end
    return b;
  endfunction

  // Start a fresh pair and wait for its name.
  function automatic void pair_reset();
    pr_name_len  = 0;
    pr_value_len = 0;
    pr_pos       = 0;
    pr_phase     = ENC_NAME_START;
  endfunction

  // Hold one name byte, or drop it once the store is full.
  function automatic logic [1:0] stash_name_byte(input logic [7:0] b);
    if (pr_name_len < NAME_DEPTH) begin
      pr_name[pr_name_len] = b;
      pr_name_len++;
      return fcgi_nv_pkg::ST_OK;
    end
    pr_overflow = 1'b1;
    drops++;
    return fcgi_nv_pkg::ST_DROPPED;
  endfunction

  function automatic bit pr_draining();
    return pr_phase == ENC_HEADER || pr_phase == ENC_SEND_NAME || pr_phase == ENC_SEND_VALUE;
  endfunction

  // Apply one accepted request to the predictor state and return its result.
  function automatic enc_result_t predict_encoding(input logic m, input logic [7:0] b);
    enc_result_t r;
    int unsigned name_hdr;
    bit          done;
    r    = '0;
    done = 1'b0;
    if (m == MODE_PUSH) begin
      if (pr_draining()) begin
        r.status = fcgi_nv_pkg::ST_REFUSED;
      end else begin
        case (pr_phase)
          ENC_NAME_START: begin
            if (b == fcgi_nv_pkg::NUL_BYTE) begin
              // zero where a name would start closes the block
              r.bdone  = 1'b1;
              r.count  = pr_total;
              pr_phase = ENC_WAIT_LEAD;
              blocks_done++;
            end else if (b == fcgi_nv_pkg::EQ_BYTE) begin
              pr_phase = ENC_VALUE;
            end else begin
              r.status = stash_name_byte(b);
              pr_phase = ENC_NAME;
            end
          end
          ENC_NAME: begin
            if (b == fcgi_nv_pkg::EQ_BYTE) begin
              pr_phase = ENC_VALUE;
            end else if (b == fcgi_nv_pkg::NUL_BYTE) begin
              pr_pos   = 0;
              pr_phase = ENC_HEADER;
            end else begin
              r.status = stash_name_byte(b);
            end
          end
          ENC_VALUE: begin
            if (b == fcgi_nv_pkg::NUL_BYTE) begin
              pr_pos   = 0;
              pr_phase = ENC_HEADER;
            end else if (pr_value_len < VALUE_DEPTH) begin
              pr_value[pr_value_len] = b;
              pr_value_len++;
            end else begin
              pr_overflow = 1'b1;
              r.status    = fcgi_nv_pkg::ST_DROPPED;
              drops++;
            end
          end
          default: begin
            // leading separator (or a stray phase): skip it, start the block
            pr_total    = '0;
            pr_overflow = 1'b0;
            pair_reset();
          end
        endcase
      end
    end else if (!pr_draining()) begin
      r.status = fcgi_nv_pkg::ST_EMPTY;
    end else begin
      case (pr_phase)
        ENC_HEADER: begin
          name_hdr = prefix_len(pr_name_len);
          if (pr_pos < name_hdr) begin
            r.obyte = prefix_byte_at(pr_name_len, pr_pos);
          end else begin
            r.obyte = prefix_byte_at(pr_value_len, pr_pos - name_hdr);
          end
        end
        ENC_SEND_NAME: r.obyte = pr_name[pr_pos];
        default:       r.obyte = pr_value[pr_pos];
      endcase
      r.ovalid = 1'b1;
      if (pr_total != fcgi_nv_pkg::TOTAL_MAX) begin
        pr_total++;
      end
      // advance through header, name, value; empty sections are skipped
      pr_pos++;
      case (pr_phase)
        ENC_HEADER: begin
          if (pr_pos >= prefix_len(pr_name_len) + prefix_len(pr_value_len)) begin
            pr_pos = 0;
            if (pr_name_len > 0) begin
              pr_phase = ENC_SEND_NAME;
            end else if (pr_value_len > 0) begin
              pr_phase = ENC_SEND_VALUE;
            end else begin
              done = 1'b1;
            end
          end
        end
        ENC_SEND_NAME: begin
          if (pr_pos >= pr_name_len) begin
            pr_pos = 0;
            if (pr_value_len > 0) begin
              pr_phase = ENC_SEND_VALUE;
            end else begin
              done = 1'b1;
            end
          end
        end
        default: done = (pr_pos >= pr_value_len);
      endcase
      if (done) begin
        r.plast = 1'b1;
        pairs_done++;
        pair_reset();
      end
    end
    return r;
  endfunction

  // Offer one request, hold it until accepted, then log what it must yield.
  // Valid is left high on return so back-to-back requests never toggle it.
  task automatic send_request(input logic m, input logic [7:0] b,
                              input bit use_row = 1'b0, input enc_result_t row_exp = '0);
    enc_result_t r;
    while (int'($urandom_range(0, 99)) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= m;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    r = predict_encoding(m, b);
    expected_results.push_back(use_row ? row_exp : r);
    requests_sent++;
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_name_byte();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == fcgi_nv_pkg::EQ_BYTE);
    return c;
  endfunction

  // Push one entry, then pull until the pair is out, with a few stray pushes.
  task automatic send_entry(input int nlen, input int vlen, input bit zero_in_name);
    for (int i = 0; i < nlen; i++) begin
      send_request(MODE_PUSH, pick_name_byte());
    end
    if (zero_in_name && nlen > 0) begin
      send_request(MODE_PUSH, fcgi_nv_pkg::NUL_BYTE);
    end else begin
      send_request(MODE_PUSH, fcgi_nv_pkg::EQ_BYTE);
      for (int i = 0; i < vlen; i++) begin
        send_request(MODE_PUSH, 8'($urandom_range(1, 255)));
      end
      send_request(MODE_PUSH, fcgi_nv_pkg::NUL_BYTE);
    end
    while (pr_draining()) begin
      if ($urandom_range(0, 99) < 4) begin
        send_request(MODE_PUSH, 8'($urandom_range(0, 255)));
      end else begin
        send_request(MODE_PULL, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Short entries; now and then a block is left open as noise.
  task automatic random_block();
    int entries;
    int nlen;
    int vlen;
    send_request(MODE_PUSH, 8'($urandom_range(0, 255)));
    entries = int'($urandom_range(0, 4));
    for (int e = 0; e < entries; e++) begin
      nlen = int'($urandom_range(0, 6));
      vlen = int'($urandom_range(0, 8));
      if ($urandom_range(0, 99) < 6) begin
        send_request(MODE_PULL, 8'($urandom_range(0, 255)));
      end
      send_entry(nlen, vlen, $urandom_range(0, 99) < 15);
    end
    if ($urandom_range(0, 99) < 94) begin
      send_request(MODE_PUSH, fcgi_nv_pkg::NUL_BYTE);
    end
  endtask

  // Length edges: a name past its store, so a long prefix and dropped bytes.
  task automatic big_block();
    send_request(MODE_PUSH, 8'($urandom_range(0, 255)));
    send_entry(NAME_DEPTH + 2, 1, 1'b0);
    send_request(MODE_PUSH, fcgi_nv_pkg::NUL_BYTE);
  endtask

  // Receiver side: stall at the rate set for the current phase.
  always @(posedge clk) begin
    out_ch.ready <= (int'($urandom_range(0, 99)) >= sink_stall_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.out_byte, out_ch.out_valid, out_ch.pair_last, out_ch.block_done,
             out_ch.status, out_ch.encoded_count};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result with no request pending: byte=%02h valid=%0b status=%0d",
                   $realtime, got.obyte, got.ovalid, got.status);
        end
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.obyte !== want.obyte || got.ovalid !== want.ovalid ||
            got.plast !== want.plast || got.bdone !== want.bdone ||
            got.status !== want.status || got.count !== want.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result %0d expected byte=%02h valid=%0b last=%0b done=%0b st=%0d cnt=%0d",
                     $realtime, results_checked, want.obyte, want.ovalid, want.plast,
                     want.bdone, want.status, want.count);
            $display("%0t: result %0d actual   byte=%02h valid=%0b last=%0b done=%0b st=%0d cnt=%0d",
                     $realtime, results_checked, got.obyte, got.ovalid, got.plast,
                     got.bdone, got.status, got.count);
          end
        end
      end
    end
  end

  initial begin
    int target;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= MODE_PUSH;
    in_ch.in_byte <= 8'h00;
    src_idle_pct   = 30;
    sink_stall_pct = 62;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the request table.
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_request(DIR_TABLE[i].mode, DIR_TABLE[i].data, DIR_TABLE[i].pinned, DIR_TABLE[i].exp);
    end
    wait_for_results();

    // Three idle mixes: slow receiver, slow sender, then full rate.
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct   = (ph == 0) ? 30 : (ph == 1) ? 62 : 0;
      sink_stall_pct = (ph == 0) ? 62 : (ph == 1) ? 30 : 0;
      if (ph == 0) begin
        big_block();
        // pause the sender until the encoder has fully caught up
        wait_for_results();
      end
      target = requests_sent + RANDOM_PER_PHASE;
      while (requests_sent < target) begin
        random_block();
      end
      wait_for_results();
    end

    // Let any stray late result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests, checked %0d results: %0d pairs, %0d blocks, %0d dropped bytes.",
             requests_sent, results_checked, pairs_done, blocks_done, drops);
    $display("Idle mixes 30/62, 62/30 and none; %0d mismatches.", mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
